@@ rtl/rau_pkg.sv @@
`default_nettype none
package rau_pkg;
    localparam int VW = 64;
    localparam int CW = 7;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    localparam logic [2:0] DOP_DIV  = 3'd0;
    localparam logic [2:0] DOP_MUL  = 3'd1;
    localparam logic [2:0] DOP_GCD  = 3'd2;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic [VW-1:0] x;
        logic [VW-1:0] y;
    } dp_cmd_t;

    typedef struct packed {
        logic          done;
        logic          ovf;
        logic [VW-1:0] q;
        logic [VW-1:0] r;
    } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
// Channel | Port group | Fields (low bit first)
// input   | s_axis     | tuser: req_type; tdata: a_num a_den a_neg b_num b_den b_neg
// output  | m_axis     | tuser: status; tdata: res_num res_den res_neg
// Each item is worked through the shared datapath unit by division,
// multiplication and binary gcd steps, with nine divisions for add and
// subtract and six for multiply and divide. Invalid operands give a
// result on the next cycle.
// Reset is synchronous; the next item is taken when the result is taken.
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [263:0] s_axis_tdata,  // a_num, a_den, a_neg, b_num, b_den, b_neg
    input  wire logic [1:0]   s_axis_tuser,  // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,  // res_num, res_den, res_neg
    output logic [1:0]        m_axis_tuser   // status
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [VW-1:0] rn, rd;
    logic rneg;
    logic [1:0] rs;

    rau_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op_in(s_axis_tuser),
        .an_in(s_axis_tdata[63:0]), .ad_in(s_axis_tdata[127:64]),
        .aneg_in(s_axis_tdata[128]),
        .bn_in(s_axis_tdata[192:129]), .bd_in(s_axis_tdata[256:193]),
        .bneg_in(s_axis_tdata[257]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .rn, .rd, .rneg, .rst(rs), .cmd, .sts
    );

    rau_datapath u_dp (.aclk, .aresetn, .cmd, .sts);

    assign m_axis_tdata = {7'd0, rneg, rd, rn};
    assign m_axis_tuser = rs;
endmodule
`default_nettype wire

@@ rtl/rau_datapath.sv @@
`default_nettype none
module rau_datapath
    import rau_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts
);
    logic [2:0]    op_reg, op_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] a_reg, a_next, b_reg, b_next, q_reg, q_next, r_reg, r_next;
    logic          ovf_reg, ovf_next, done_reg, done_next;
    logic [VW:0]   rem_sh, sum;
    logic [VW:0]   dif;

    always_comb begin
        op_next = op_reg; busy_next = busy_reg; cnt_next = cnt_reg;
        a_next = a_reg; b_next = b_reg; q_next = q_reg; r_next = r_reg;
        ovf_next = ovf_reg; done_next = 1'b0;
        rem_sh = {r_reg, a_reg[VW-1]};
        dif = rem_sh - {1'b0, b_reg};
        sum = {1'b0, r_reg} + {1'b0, b_reg};
        if (cmd.start) begin
            op_next = cmd.op; busy_next = 1'b1; cnt_next = '0;
            a_next = cmd.x; b_next = cmd.y; q_next = '0; r_next = '0;
            ovf_next = 1'b0;
        end else if (busy_reg) begin
            case (op_reg)
                DOP_DIV: begin
                    a_next = {a_reg[VW-2:0], 1'b0};
                    if (!dif[VW]) begin
                        r_next = dif[VW-1:0]; q_next = {q_reg[VW-2:0], 1'b1};
                    end else begin
                        r_next = rem_sh[VW-1:0]; q_next = {q_reg[VW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(VW-1)) begin
                        busy_next = 1'b0; done_next = 1'b1;
                    end
                end
                DOP_MUL: begin
                    if (a_reg[0]) begin
                        r_next = sum[VW-1:0];
                        if (sum[VW]) ovf_next = 1'b1;
                    end
                    a_next = {1'b0, a_reg[VW-1:1]};
                    if (b_reg[VW-1] && (a_reg[VW-1:1] != '0)) ovf_next = 1'b1;
                    b_next = {b_reg[VW-2:0], 1'b0};
                    if (a_reg[VW-1:1] == '0 || (ovf_next && !a_reg[0])) begin
                        busy_next = 1'b0; done_next = 1'b1;
                    end
                    if (a_reg == '0) begin
                        busy_next = 1'b0; done_next = 1'b1;
                    end
                    q_next = r_next;
                end
                DOP_GCD: begin
                    if (a_reg == '0) begin
                        busy_next = 1'b0; done_next = 1'b1; q_next = b_reg << cnt_reg;
                    end else if (b_reg == '0) begin
                        busy_next = 1'b0; done_next = 1'b1; q_next = a_reg << cnt_reg;
                    end else if (!a_reg[0] && !b_reg[0]) begin
                        a_next = a_reg >> 1; b_next = b_reg >> 1;
                        cnt_next = cnt_reg + CW'(1);
                    end else if (!a_reg[0]) begin
                        a_next = a_reg >> 1;
                    end else if (!b_reg[0]) begin
                        b_next = b_reg >> 1;
                    end else if (a_reg >= b_reg) begin
                        a_next = (a_reg - b_reg) >> 1;
                    end else begin
                        b_next = (b_reg - a_reg) >> 1;
                    end
                end
                default: begin
                    busy_next = 1'b0; done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
        op_reg <= op_next; cnt_reg <= cnt_next; a_reg <= a_next; b_reg <= b_next;
        q_reg <= q_next; r_reg <= r_next; ovf_reg <= ovf_next;
    end

    assign sts = '{done: done_reg, ovf: ovf_reg, q: q_reg, r: r_reg};
endmodule
`default_nettype wire

@@ rtl/rau_ctrl.sv @@
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    op_in,
    input  wire logic [VW-1:0] an_in, ad_in, bn_in, bd_in,
    input  wire logic          aneg_in, bneg_in,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [VW-1:0]      rn, rd,
    output logic               rneg,
    output logic [1:0]         rst,
    output dp_cmd_t            cmd,
    input  wire dp_sts_t       sts
);
    localparam logic [4:0] S_IDLE = 5'd0, S_G1 = 5'd1, S_AN = 5'd2, S_AD = 5'd3,
        S_G2 = 5'd4, S_BN = 5'd5, S_BD = 5'd6, S_SEL = 5'd7, S_LG = 5'd8,
        S_LQ = 5'd9, S_LM = 5'd10, S_SA1 = 5'd11, S_SA2 = 5'd12, S_SB1 = 5'd13,
        S_SB2 = 5'd14, S_SUM = 5'd15, S_MN = 5'd16, S_MD = 5'd17, S_RG = 5'd18,
        S_RN = 5'd19, S_RD = 5'd20, S_OUT = 5'd21;

    logic [4:0]    st_reg, st_next;
    logic [1:0]    op_reg, op_next;
    logic [VW-1:0] an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    logic          aneg_reg, aneg_next, bneg_reg, bneg_next;
    logic [VW-1:0] g_reg, g_next, l_reg, l_next, sa_reg, sa_next, sb_reg, sb_next;
    logic [VW-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic          rneg_reg, rneg_next, ov_reg, ov_next;
    logic [1:0]    rs_reg, rs_next;
    logic          go;
    logic [VW:0]   s;

    assign go = cmd.start;
    assign in_ready = (st_reg == S_IDLE) || (st_reg == S_OUT && out_ready);
    assign out_valid = (st_reg == S_OUT);
    assign rn = rn_reg; assign rd = rd_reg; assign rneg = rneg_reg; assign rst = rs_reg;

    always_comb begin
        st_next = st_reg; op_next = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        aneg_next = aneg_reg; bneg_next = bneg_reg; g_next = g_reg; l_next = l_reg;
        sa_next = sa_reg; sb_next = sb_reg; rn_next = rn_reg; rd_next = rd_reg;
        rneg_next = rneg_reg; rs_next = rs_reg; ov_next = ov_reg;
        cmd = '{start: 1'b0, op: DOP_GCD, x: '0, y: '0};
        s = '0;
        if (in_valid && in_ready) begin
            op_next = op_in; an_next = an_in; ad_next = ad_in; aneg_next = aneg_in;
            bn_next = bn_in; bd_next = bd_in; bneg_next = bneg_in;
            rn_next = '0; rd_next = '0; rneg_next = 1'b0; ov_next = 1'b0;
            if (ad_in == '0 || bd_in == '0 || (op_in == OP_DIV && bn_in == '0)) begin
                rs_next = ST_ERR; st_next = S_OUT;
            end else begin
                rs_next = ST_OK; st_next = S_G1;
                cmd = '{start: 1'b1, op: DOP_GCD, x: an_in, y: ad_in};
            end
        end else begin
            case (st_reg)
                S_IDLE: ;
                S_OUT: if (out_ready) st_next = S_IDLE;
                S_G1, S_G2, S_LG, S_RG: if (sts.done) begin
                    g_next = sts.q;
                    st_next = st_reg + 5'd1;
                    cmd.start = 1'b1; cmd.op = DOP_DIV;
                    cmd.y = (sts.q == '0) ? VW'(1) : sts.q;
                    case (st_reg)
                        S_G1: cmd.x = an_reg;
                        S_G2: cmd.x = bn_reg;
                        S_LG: cmd.x = ad_reg;
                        default: cmd.x = rn_reg;
                    endcase
                end
                S_AN, S_BN, S_RN: if (sts.done) begin
                    if (st_reg == S_AN) an_next = sts.q;
                    else if (st_reg == S_BN) bn_next = sts.q;
                    else rn_next = sts.q;
                    st_next = st_reg + 5'd1;
                    cmd.start = 1'b1; cmd.op = DOP_DIV;
                    cmd.y = (g_reg == '0) ? VW'(1) : g_reg;
                    cmd.x = (st_reg == S_AN) ? ad_reg : (st_reg == S_BN) ? bd_reg : rd_reg;
                end
                S_AD: if (sts.done) begin
                    ad_next = sts.q;
                    if (an_reg == '0) begin ad_next = VW'(1); aneg_next = 1'b0; end
                    st_next = S_G2;
                    cmd = '{start: 1'b1, op: DOP_GCD, x: bn_reg, y: bd_reg};
                end
                S_BD: if (sts.done) begin
                    bd_next = sts.q;
                    if (bn_reg == '0) begin bd_next = VW'(1); bneg_next = 1'b0; end
                    st_next = S_SEL;
                end
                S_SEL: begin
                    if (op_reg == OP_SUB) bneg_next = !bneg_reg;
                    if (op_reg == OP_DIV) begin bn_next = bd_reg; bd_next = bn_reg; end
                    if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                        st_next = S_LG;
                        cmd = '{start: 1'b1, op: DOP_GCD, x: ad_reg, y: bd_reg};
                    end else begin
                        st_next = S_MN;
                        cmd = '{start: 1'b1, op: DOP_MUL, x: an_reg,
                                y: (op_reg == OP_DIV) ? bd_reg : bn_reg};
                    end
                end
                S_LQ: if (sts.done) begin
                    st_next = S_LM;
                    cmd = '{start: 1'b1, op: DOP_MUL, x: sts.q, y: bd_reg};
                end
                S_LM: if (sts.done) begin
                    l_next = sts.q; ov_next = sts.ovf;
                    st_next = S_SA1;
                    cmd = '{start: 1'b1, op: DOP_DIV, x: sts.q, y: ad_reg};
                end
                S_SA1: if (sts.done) begin
                    st_next = S_SA2;
                    cmd = '{start: 1'b1, op: DOP_MUL, x: an_reg, y: sts.q};
                end
                S_SA2: if (sts.done) begin
                    sa_next = sts.q; ov_next = ov_reg | sts.ovf;
                    st_next = S_SB1;
                    cmd = '{start: 1'b1, op: DOP_DIV, x: l_reg, y: bd_reg};
                end
                S_SB1: if (sts.done) begin
                    st_next = S_SB2;
                    cmd = '{start: 1'b1, op: DOP_MUL, x: bn_reg, y: sts.q};
                end
                S_SB2: if (sts.done) begin
                    sb_next = sts.q; ov_next = ov_reg | sts.ovf;
                    st_next = S_SUM;
                end
                S_SUM: begin
                    rd_next = l_reg;
                    s = {1'b0, sa_reg} + {1'b0, sb_reg};
                    if (aneg_reg == bneg_reg) begin
                        rn_next = s[VW-1:0]; rneg_next = aneg_reg;
                        if (s[VW]) ov_next = 1'b1;
                    end else if (sa_reg >= sb_reg) begin
                        rn_next = sa_reg - sb_reg; rneg_next = aneg_reg;
                    end else begin
                        rn_next = sb_reg - sa_reg; rneg_next = bneg_reg;
                    end
                    if (ov_reg || (aneg_reg == bneg_reg && s[VW])) begin
                        rs_next = ST_OVF; rn_next = '0; rd_next = '0; rneg_next = 1'b0;
                        st_next = S_OUT;
                    end else begin
                        st_next = S_RG;
                        cmd = '{start: 1'b1, op: DOP_GCD, x: rn_next, y: l_reg};
                    end
                end
                S_MN: if (sts.done) begin
                    rn_next = sts.q; ov_next = sts.ovf; st_next = S_MD;
                    rneg_next = aneg_reg != bneg_reg;
                    cmd = '{start: 1'b1, op: DOP_MUL, x: ad_reg, y: bd_reg};
                end
                S_MD: if (sts.done) begin
                    rd_next = sts.q;
                    if (ov_reg || sts.ovf) begin
                        rs_next = ST_OVF; rn_next = '0; rd_next = '0; rneg_next = 1'b0;
                        st_next = S_OUT;
                    end else begin
                        st_next = S_RG;
                        cmd = '{start: 1'b1, op: DOP_GCD, x: rn_reg, y: sts.q};
                    end
                end
                S_RD: if (sts.done) begin
                    rd_next = sts.q;
                    if (rn_reg == '0) begin rd_next = VW'(1); rneg_next = 1'b0; end
                    st_next = S_OUT;
                end
                default: st_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
        op_reg <= op_next; an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next;
        bd_reg <= bd_next; aneg_reg <= aneg_next; bneg_reg <= bneg_next;
        g_reg <= g_next; l_reg <= l_next; sa_reg <= sa_next; sb_reg <= sb_next;
        rn_reg <= rn_next; rd_reg <= rd_next; rneg_reg <= rneg_next;
        rs_reg <= rs_next; ov_reg <= ov_next;
    end
    logic unused;
    assign unused = go ^ ^sts.r;
endmodule
`default_nettype wire

@@ rtl/rau_checker.sv @@
`default_nettype none
module rau_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tdata == '0)
        else $error("error result not zero");
    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == 2'd0 |-> m_axis_tdata[127:64] != '0)
        else $error("zero denominator on good result");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad status");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (.*);
`default_nettype wire
